// ===== src/crsf_pkg.sv =====
// ============================================================================
// CRSF receiver package
// Shared types, constants and the CRC-8 byte step for the CRSF RC frame
// receiver.
// ============================================================================
package crsf_pkg;

    localparam logic [7:0] CRC_POLY   = 8'hD5;
    localparam logic [7:0] ADDR_FC    = 8'hC8;
    localparam logic [7:0] ADDR_RX    = 8'hEE;
    localparam logic [7:0] ADDR_TX    = 8'hEA;
    localparam logic [7:0] ADDR_RC    = 8'hEC;
    localparam logic [7:0] TYPE_RC    = 8'h16;
    localparam logic [7:0] RC_LEN     = 8'd24;
    localparam logic [4:0] RC_PAYLOAD = 5'd22;
    localparam int         CH_BITS    = 11;
    localparam int         MAX_RESULTS = 32;

    localparam logic [1:0] CFG_CENTER = 2'd0;
    localparam logic [1:0] CFG_LOW    = 2'd1;
    localparam logic [1:0] CFG_HIGH   = 2'd2;

    localparam logic [10:0] RST_CENTER = 11'd992;
    localparam logic [10:0] RST_LOW    = 11'd700;
    localparam logic [10:0] RST_HIGH   = 11'd1300;

    // Cursor update selects.
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_ONE,
        CUR_TWO,
        CUR_INC,
        CUR_FCS,
        CUR_CHAN
    } t_cur_op;

    // Capture selects for the registered read data.
    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_LEN,
        CAP_W0,
        CAP_W1,
        CAP_W2
    } t_cap;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    push;
        logic    step_clr;
        t_cur_op cur_op;
        t_cap    cap;
        logic    crc_clr;
        logic    crc_step;
        logic    drop1;
        logic    drop_frame;
        logic    rc_done;
        logic    ch_clr;
        logic    ch_next;
        logic    emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_ge2;
        logic is_addr;
        logic len_ok;
        logic have_frame;
        logic crc_done;
        logic crc_ok;
        logic is_rc;
        logic ch_last;
        logic out_free;
    } t_status;

    // One byte of the CRC-8, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

// ===== src/crsf_rx_if.sv =====
// ============================================================================
// CRSF byte channel
// Valid/ready channel that carries one received serial byte.
// ============================================================================
interface crsf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/crsf_ch_if.sv =====
// ============================================================================
// CRSF channel result channel
// Valid/ready channel that carries one decoded RC channel.
// ============================================================================
interface crsf_ch_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel_index;
    logic [10:0]        raw_value;
    logic signed [11:0] centered_value;
    logic [1:0]         three_position;
    logic               two_position;
    logic               key_pressed;
    logic               last_channel;

    modport source (output valid, output channel_index, output raw_value,
                    output centered_value, output three_position, output two_position,
                    output key_pressed, output last_channel, input ready);
    modport sink (input valid, input channel_index, input raw_value,
                  input centered_value, input three_position, input two_position,
                  input key_pressed, input last_channel, output ready);
endinterface

// ===== src/crsf_rc_frame_receiver.sv =====
// ============================================================================
// CRSF RC frame receiver
// Hunts for CRSF frames in a byte stream, checks length and CRC-8, and
// unpacks RC channel frames into one result per channel.
// ============================================================================
// A byte is accepted only in the idle state; the next byte waits for all work it causes.
// Hunting drops one byte when the address test (ST_CHECK, ST_ADDR_W, ST_ADDR) fails or
// when the length test (adding ST_LEN_W, ST_LEN, ST_LEN_CHK) fails; the CRC unit reads
// one byte at a time through the single buffer read port, waiting in ST_CRC_W for each.
// Each channel result takes three buffer reads and waits in ST_OUT for any output stall.
// Synchronous active-low reset empties the buffer and loads default thresholds.
module crsf_rc_frame_receiver #(
    parameter int MAX_FRAME_BYTES = 64,
    parameter int CHANNEL_COUNT   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crsf_rx_if.sink     i_rx,
    crsf_ch_if.source   o_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data
);
    crsf_pkg::t_cmd    cmd;
    crsf_pkg::t_status status;

    // Sequencer.
    crsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .o_rx_ready (i_rx.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Buffer, checks and unpacking.
    crsf_datapath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .CHANNEL_COUNT   (CHANNEL_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_rx_byte  (i_rx.rx_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ch       (o_ch)
    );
endmodule

// ===== src/crsf_datapath.sv =====
// ============================================================================
// CRSF receiver datapath
// Byte buffer, cursor, CRC unit, channel unpacker and output register.
// ============================================================================
module crsf_datapath #(
    parameter int MAX_FRAME_BYTES = 64,
    parameter int CHANNEL_COUNT   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  crsf_pkg::t_cmd   i_cmd,
    output crsf_pkg::t_status o_status,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [10:0]      i_cfg_data,
    crsf_ch_if.source        o_ch
);
    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] MAX_S = SW'(MAX_FRAME_BYTES);
    localparam logic [9:0] MAX_10 = 10'(MAX_FRAME_BYTES);
    localparam logic [3:0] CH_LAST = 4'(CHANNEL_COUNT - 1);
    localparam logic [6:0] CH_N = 7'(CHANNEL_COUNT);
    localparam int CH_BITS_C = crsf_pkg::CH_BITS;

    logic [7:0]    mem [MAX_FRAME_BYTES];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_cur;
    logic [7:0]    r_len;
    logic [7:0]    r_type;
    logic [7:0]    r_crc;
    logic [23:0]   r_word;
    logic [3:0]    r_ch;
    logic [6:0]    r_nres;
    logic [10:0]   r_center, r_low, r_high;
    logic          r_ovalid;

    logic [SW-1:0] s_rd, s_wr, s_head;
    logic [AW-1:0] rd_addr, wr_addr, n_head;
    logic [9:0]    len_total;
    logic [7:0]    off;
    logic [4:0]    bi;
    logic [4:0]    bi_k;
    logic          in_frame;
    logic [23:0]   shifted;
    logic [10:0]   raw;
    logic          out_free;

    // Circular addressing relative to the head.
    always_comb begin
        s_rd = SW'(r_head) + SW'(r_cur);
        rd_addr = (s_rd >= MAX_S) ? AW'(s_rd - MAX_S) : AW'(s_rd);
        s_wr = SW'(r_head) + SW'(r_count);
        wr_addr = (s_wr >= MAX_S) ? AW'(s_wr - MAX_S) : AW'(s_wr);
        s_head = SW'(r_head) + (i_cmd.drop_frame ? SW'(len_total) : SW'(1));
        n_head = (s_head >= MAX_S) ? AW'(s_head - MAX_S) : AW'(s_head);
    end

    assign len_total = 10'(r_len) + 10'd2;
    assign off = 8'(r_ch) * 8'(CH_BITS_C);
    assign bi = off[7:3];
    assign out_free = !r_ovalid || o_ch.ready;

    // Which byte of the three-byte window is being captured.
    always_comb begin
        case (i_cmd.cap)
            crsf_pkg::CAP_W1: bi_k = bi + 5'd1;
            crsf_pkg::CAP_W2: bi_k = bi + 5'd2;
            default:          bi_k = bi;
        endcase
        in_frame = bi_k < crsf_pkg::RC_PAYLOAD;
    end

    // Status flags for the controller.
    always_comb begin
        o_status.cnt_ge2    = r_count >= CW'(2);
        o_status.is_addr    = (r_rdata == crsf_pkg::ADDR_FC) || (r_rdata == crsf_pkg::ADDR_RX)
                           || (r_rdata == crsf_pkg::ADDR_TX) || (r_rdata == crsf_pkg::ADDR_RC);
        o_status.len_ok     = (r_len >= 8'd2) && (len_total <= MAX_10);
        o_status.have_frame = 10'(r_count) >= len_total;
        o_status.crc_done   = 10'(r_cur) == 10'(r_len);
        o_status.crc_ok     = r_crc == r_rdata;
        o_status.is_rc      = (r_type == crsf_pkg::TYPE_RC) && (r_len == crsf_pkg::RC_LEN)
                           && (r_nres + CH_N <= 7'(crsf_pkg::MAX_RESULTS));
        o_status.ch_last    = r_ch == CH_LAST;
        o_status.out_free   = out_free;
    end

    // Byte buffer memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (r_count < CW'(MAX_FRAME_BYTES))) begin
            mem[wr_addr] <= i_rx_byte;
        end
        r_rdata <= mem[rd_addr];
    end

    // Buffer pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.push) begin
            if (r_count < CW'(MAX_FRAME_BYTES)) begin
                r_count <= r_count + CW'(1);
            end
        end else if (i_cmd.drop1) begin
            r_head  <= n_head;
            r_count <= r_count - CW'(1);
        end else if (i_cmd.drop_frame) begin
            r_head  <= n_head;
            r_count <= r_count - CW'(len_total);
        end
    end

    // Cursor.
    always_ff @(posedge i_clk) begin
        case (i_cmd.cur_op)
            crsf_pkg::CUR_ZERO: r_cur <= '0;
            crsf_pkg::CUR_ONE:  r_cur <= AW'(1);
            crsf_pkg::CUR_TWO:  r_cur <= AW'(2);
            crsf_pkg::CUR_INC:  r_cur <= r_cur + AW'(1);
            crsf_pkg::CUR_FCS:  r_cur <= AW'(r_len + 8'd1);
            crsf_pkg::CUR_CHAN: r_cur <= AW'(bi + 5'd3);
            default:            r_cur <= r_cur;
        endcase
    end

    // Header capture, CRC and channel word assembly.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap == crsf_pkg::CAP_LEN) begin
            r_len <= r_rdata;
        end
        if (i_cmd.crc_clr) begin
            r_crc <= '0;
        end else if (i_cmd.crc_step) begin
            r_crc <= crsf_pkg::crc8_byte(r_crc, r_rdata);
            if (r_cur == AW'(2)) begin
                r_type <= r_rdata;
            end
        end
        case (i_cmd.cap)
            crsf_pkg::CAP_W0: r_word[7:0]   <= in_frame ? r_rdata : 8'd0;
            crsf_pkg::CAP_W1: r_word[15:8]  <= in_frame ? r_rdata : 8'd0;
            crsf_pkg::CAP_W2: r_word[23:16] <= in_frame ? r_rdata : 8'd0;
            default: ;
        endcase
        if (i_cmd.ch_clr) begin
            r_ch <= '0;
        end else if (i_cmd.ch_next) begin
            r_ch <= r_ch + 4'd1;
        end
    end

    // Results counted within one accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.step_clr) begin
            r_nres <= '0;
        end else if (i_cmd.rc_done) begin
            r_nres <= r_nres + CH_N;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= crsf_pkg::RST_CENTER;
            r_low    <= crsf_pkg::RST_LOW;
            r_high   <= crsf_pkg::RST_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crsf_pkg::CFG_CENTER: r_center <= i_cfg_data;
                crsf_pkg::CFG_LOW:    r_low    <= i_cfg_data;
                crsf_pkg::CFG_HIGH:   r_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign shifted = r_word >> off[2:0];
    assign raw = shifted[10:0];

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_ch.ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.emit) begin
            o_ch.channel_index  <= r_ch;
            o_ch.raw_value      <= raw;
            o_ch.centered_value <= signed'(12'(raw) - 12'(r_center));
            o_ch.three_position <= (raw < r_low) ? 2'd0 : ((raw < r_high) ? 2'd1 : 2'd2);
            o_ch.two_position   <= raw >= r_center;
            o_ch.key_pressed    <= raw <= r_high;
            o_ch.last_channel   <= r_ch == CH_LAST;
        end
    end
    assign o_ch.valid = r_ovalid;

    // Buffer never holds more than its depth.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FRAME_BYTES)) else $error("buffer count overflow");
    // A frame is consumed only when fully buffered.
    a_drop_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drop_frame |-> (10'(r_count) >= len_total)) else $error("frame drop underflow");
    // A result is loaded only into a free output register.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free) else $error("output overwritten");
endmodule

// ===== src/crsf_ctrl.sv =====
// ============================================================================
// CRSF receiver controller
// Sequences hunting, length check, CRC check and channel unpacking.
// ============================================================================
module crsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  crsf_pkg::t_status i_status,
    output crsf_pkg::t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_ADDR_W, ST_ADDR, ST_LEN_W, ST_LEN, ST_LEN_CHK,
        ST_CRC_W, ST_CRC, ST_FCS_W, ST_FCS, ST_CH_SET,
        ST_W0_W, ST_W0, ST_W1_W, ST_W1, ST_W2_W, ST_W2, ST_OUT
    } t_state;

    t_state r_state, n_state;

    assign o_rx_ready = r_state == ST_IDLE;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.cur_op = crsf_pkg::CUR_HOLD;
        o_cmd.cap = crsf_pkg::CAP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_rx_valid) begin
                    o_cmd.push = 1'b1;
                    o_cmd.step_clr = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_status.cnt_ge2) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.cur_op = crsf_pkg::CUR_ZERO;
                    n_state = ST_ADDR_W;
                end
            end
            ST_ADDR_W: n_state = ST_ADDR;
            ST_ADDR: begin
                if (!i_status.is_addr) begin
                    o_cmd.drop1 = 1'b1;
                    n_state = ST_CHECK;
                end else begin
                    o_cmd.cur_op = crsf_pkg::CUR_ONE;
                    n_state = ST_LEN_W;
                end
            end
            ST_LEN_W: n_state = ST_LEN;
            ST_LEN: begin
                o_cmd.cap = crsf_pkg::CAP_LEN;
                n_state = ST_LEN_CHK;
            end
            ST_LEN_CHK: begin
                if (!i_status.len_ok) begin
                    o_cmd.drop1 = 1'b1;
                    n_state = ST_CHECK;
                end else if (!i_status.have_frame) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.crc_clr = 1'b1;
                    o_cmd.cur_op = crsf_pkg::CUR_TWO;
                    n_state = ST_CRC_W;
                end
            end
            ST_CRC_W: n_state = ST_CRC;
            ST_CRC: begin
                o_cmd.crc_step = 1'b1;
                if (i_status.crc_done) begin
                    o_cmd.cur_op = crsf_pkg::CUR_FCS;
                    n_state = ST_FCS_W;
                end else begin
                    o_cmd.cur_op = crsf_pkg::CUR_INC;
                    n_state = ST_CRC_W;
                end
            end
            ST_FCS_W: n_state = ST_FCS;
            ST_FCS: begin
                if (!i_status.crc_ok) begin
                    o_cmd.drop1 = 1'b1;
                    n_state = ST_CHECK;
                end else if (i_status.is_rc) begin
                    o_cmd.ch_clr = 1'b1;
                    n_state = ST_CH_SET;
                end else begin
                    o_cmd.drop_frame = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CH_SET: begin
                o_cmd.cur_op = crsf_pkg::CUR_CHAN;
                n_state = ST_W0_W;
            end
            ST_W0_W: n_state = ST_W0;
            ST_W0: begin
                o_cmd.cap = crsf_pkg::CAP_W0;
                o_cmd.cur_op = crsf_pkg::CUR_INC;
                n_state = ST_W1_W;
            end
            ST_W1_W: n_state = ST_W1;
            ST_W1: begin
                o_cmd.cap = crsf_pkg::CAP_W1;
                o_cmd.cur_op = crsf_pkg::CUR_INC;
                n_state = ST_W2_W;
            end
            ST_W2_W: n_state = ST_W2;
            ST_W2: begin
                o_cmd.cap = crsf_pkg::CAP_W2;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.ch_last) begin
                        o_cmd.drop_frame = 1'b1;
                        o_cmd.rc_done = 1'b1;
                        n_state = ST_CHECK;
                    end else begin
                        o_cmd.ch_next = 1'b1;
                        n_state = ST_CH_SET;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Only one buffer update per cycle.
    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.push, o_cmd.drop1, o_cmd.drop_frame}) <= 1)
        else $error("conflicting buffer updates");
    // A push is always followed by a buffer check.
    a_push_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |=> (r_state == ST_CHECK)) else $error("push not followed by check");
    // Frame consumed with results only at the last channel.
    a_rc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rc_done |-> (o_cmd.emit && i_status.ch_last)) else $error("early frame end");
endmodule
